FILE: rtl/cmmp_pkg.sv
// Shared types, constants and helpers for the complex matrix multiply/power block.
// No dependencies; imported by the top level, cmmp_cmul and cmmp_acc_cell.
`timescale 1ns / 1ps

package cmmp_pkg;

    localparam int MAX_DIM_DEF   = 8;
    localparam int FRAC_BITS_DEF = 16;
    localparam int DATA_W        = 32;
    localparam int ELEM_W        = 2 * DATA_W;

    // Configuration register indexes.
    localparam logic [2:0] REG_MODE   = 3'd0;
    localparam logic [2:0] REG_A_ROWS = 3'd1;
    localparam logic [2:0] REG_A_COLS = 3'd2;
    localparam logic [2:0] REG_B_ROWS = 3'd3;
    localparam logic [2:0] REG_B_COLS = 3'd4;
    localparam logic [2:0] REG_EXP    = 3'd5;

    localparam logic MODE_MUL = 1'b0;

    // Tag that travels with an operand pair through the product pipeline.
    typedef struct packed {
        logic valid;
        logic first;
    } cmmp_tag_t;

    function automatic logic signed [DATA_W-1:0] sat32(input logic signed [63:0] v);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        hi = 64'sd2147483647;
        lo = -64'sd2147483648;
        if (v > hi) begin
            return 32'h7fffffff;
        end else if (v < lo) begin
            return 32'h80000000;
        end else begin
            return v[DATA_W-1:0];
        end
    endfunction

endpackage

FILE: rtl/complex_matrix_mul_power.sv
// Top level: loads A and B, multiplies or raises A to a power, streams the result.
// Depends on cmmp_pkg, cmmp_ram, cmmp_cmul and cmmp_acc_cell.
//
// channel  direction  handshake                 payload
// s_       in         s_tvalid/s_tready         s_tdata, s_tuser, s_tlast
// m_       out        m_tvalid/m_tready         m_tdata, m_tuser, m_tlast
// cfg_     in         cfg_valid/cfg_ready       cfg_index, cfg_data
//
// Loading accepts one item per cycle while idle. After the last element each matrix
// product is computed by the single complex product pipeline feeding the ring of
// MAX_DIM accumulator cells; a power run takes exponent-1 products. Each result
// item is then read from its source, registered and held until m_tready takes it.
// No input is taken from the last element until the last result is delivered.
// aresetn is synchronous and active low; stores need no clearing.
`timescale 1ns / 1ps

module complex_matrix_mul_power
    import cmmp_pkg::*;
#(
    parameter int MAX_DIM   = MAX_DIM_DEF,
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // elem_real [31:0], elem_imag [63:32]
    input  logic [0:0]  s_tuser,   // which_matrix [0]
    input  logic        s_tlast,   // last_element
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [71:0] m_tdata,   // out_real [31:0], out_imag [63:32], out_row [66:64],
                                   // out_col [69:67], zero fill [71:70]
    output logic [0:0]  m_tuser,   // empty_result [0]
    output logic        m_tlast,   // last_result
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [2:0]  cfg_index,
    input  logic [7:0]  cfg_data
);

    localparam int CELLS = MAX_DIM * MAX_DIM;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int DW    = $clog2(MAX_DIM + 1);
    localparam int IW    = $clog2(MAX_DIM);
    localparam int PW    = 65 - FRAC_BITS;
    localparam int W     = PW + $clog2(MAX_DIM) + 1;
    localparam logic [IW-1:0] IDX_LAST = IW'(MAX_DIM - 1);
    localparam logic signed [DATA_W-1:0] ONE = DATA_W'(1) << FRAC_BITS;

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_CALC  = 3'd1;
    localparam logic [2:0] ST_WAIT  = 3'd2;
    localparam logic [2:0] ST_DRAIN = 3'd3;
    localparam logic [2:0] ST_ERD   = 3'd4;
    localparam logic [2:0] ST_ELD   = 3'd5;
    localparam logic [2:0] ST_EHOLD = 3'd6;

    localparam logic [1:0] SRC_IDENT = 2'd0;
    localparam logic [1:0] SRC_A     = 2'd1;
    localparam logic [1:0] SRC_WORK  = 2'd2;

    function automatic logic [DW-1:0] clamp(input logic [3:0] v);
        if (v == 4'd0) begin
            return DW'(1);
        end else if (v > 4'(MAX_DIM)) begin
            return DW'(MAX_DIM);
        end else begin
            return DW'(v);
        end
    endfunction

    logic [2:0] state_reg;
    logic       mode_reg;
    logic [3:0] a_rows_reg, a_cols_reg, b_rows_reg, b_cols_reg;
    logic [7:0] exp_reg;
    logic [LW-1:0] la_reg, lb_reg;

    logic [DW-1:0] xr_reg, n_reg, yc_reg, erows_reg, ecols_reg;
    logic [7:0]    left_reg;
    logic          xwork_reg, ya_reg, xbank_reg, dbank_reg;
    logic [IW-1:0] r_reg, k_reg, c_reg, er_reg, ec_reg;
    logic [1:0]    esrc_reg;
    cmmp_tag_t     iss_reg;
    logic          iss_mask_reg;

    logic signed [DATA_W-1:0] o_re_reg, o_im_reg;
    logic [2:0] o_row_reg, o_col_reg;
    logic       o_empty_reg, o_last_reg;

    logic accept, cfg_we;
    logic [DW-1:0] ar, ac, br, bc;
    logic [AW:0] xa_w, ya_w, da_w, ea_w;
    logic [AW-1:0] x_addr, y_addr, d_addr, e_addr;
    logic [ELEM_W-1:0] a_rd_a, a_rd_b, b_rd, w_rd, x_rd, y_rd, s_elem, w_wr;
    logic a_we, b_we, w_we;
    logic [AW-1:0] a_raddr;
    logic [AW:0]   w_raddr;
    logic last_k, last_r, last_e;

    cmmp_tag_t p_tag;
    logic signed [PW-1:0] p_re, p_im;
    logic p_busy;

    logic signed [W-1:0] acc_re [MAX_DIM];
    logic signed [W-1:0] acc_im [MAX_DIM];
    logic signed [W-1:0] prod_re, prod_im;
    logic ring_shift, ring_clear;

    assign s_tready  = (state_reg == ST_IDLE);
    assign accept    = s_tvalid & s_tready;
    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid & cfg_ready;

    assign ar = clamp(a_rows_reg);
    assign ac = clamp(a_cols_reg);
    assign br = clamp(b_rows_reg);
    assign bc = clamp(b_cols_reg);

    assign xa_w   = (AW + 1)'(r_reg) * (AW + 1)'(n_reg) + (AW + 1)'(k_reg);
    assign ya_w   = (AW + 1)'(k_reg) * (AW + 1)'(yc_reg) + (AW + 1)'(c_reg);
    assign da_w   = (AW + 1)'(r_reg) * (AW + 1)'(yc_reg) + (AW + 1)'(c_reg);
    assign ea_w   = (AW + 1)'(er_reg) * (AW + 1)'(ecols_reg) + (AW + 1)'(ec_reg);
    assign x_addr = xa_w[AW-1:0];
    assign y_addr = ya_w[AW-1:0];
    assign d_addr = da_w[AW-1:0];
    assign e_addr = ea_w[AW-1:0];

    assign last_k = (DW'(k_reg) + DW'(1)) == n_reg;
    assign last_r = (DW'(r_reg) + DW'(1)) == xr_reg;
    assign last_e = ((DW'(er_reg) + DW'(1)) == erows_reg) &&
                    ((DW'(ec_reg) + DW'(1)) == ecols_reg);

    assign s_elem  = s_tdata;
    assign a_we    = accept & ~s_tuser[0] & (la_reg < LW'(CELLS));
    assign b_we    = accept & s_tuser[0] & (lb_reg < LW'(CELLS));
    assign a_raddr = (state_reg == ST_CALC) ? x_addr : e_addr;
    assign w_raddr = (state_reg == ST_CALC) ? {xbank_reg, x_addr} : {dbank_reg, e_addr};
    assign w_we    = (state_reg == ST_DRAIN) && (DW'(c_reg) < yc_reg);
    assign w_wr    = {sat32(64'(acc_im[MAX_DIM-1])), sat32(64'(acc_re[MAX_DIM-1]))};

    cmmp_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_store_a (
        .aclk      (aclk),
        .we        (a_we),
        .wr_addr   (la_reg[AW-1:0]),
        .wr_data   (s_elem),
        .rd_addr_a (a_raddr),
        .rd_data_a (a_rd_a),
        .rd_addr_b (y_addr),
        .rd_data_b (a_rd_b)
    );

    cmmp_ram #(.WIDTH(ELEM_W), .DEPTH(CELLS)) u_store_b (
        .aclk      (aclk),
        .we        (b_we),
        .wr_addr   (lb_reg[AW-1:0]),
        .wr_data   (s_elem),
        .rd_addr_a (y_addr),
        .rd_data_a (b_rd),
        .rd_addr_b (y_addr),
        .rd_data_b ()
    );

    // Two banks: a power step reads one bank while writing the other.
    cmmp_ram #(.WIDTH(ELEM_W), .DEPTH(2 * CELLS)) u_work (
        .aclk      (aclk),
        .we        (w_we),
        .wr_addr   ({dbank_reg, d_addr}),
        .wr_data   (w_wr),
        .rd_addr_a (w_raddr),
        .rd_data_a (w_rd),
        .rd_addr_b (w_raddr),
        .rd_data_b ()
    );

    assign x_rd = iss_mask_reg ? (xwork_reg ? w_rd : a_rd_a) : '0;
    assign y_rd = iss_mask_reg ? (ya_reg ? a_rd_b : b_rd) : '0;

    cmmp_cmul #(.FRAC_BITS(FRAC_BITS)) u_cmul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .in_tag  (iss_reg),
        .x_re    (x_rd[31:0]),
        .x_im    (x_rd[63:32]),
        .y_re    (y_rd[31:0]),
        .y_im    (y_rd[63:32]),
        .out_tag (p_tag),
        .p_re    (p_re),
        .p_im    (p_im),
        .busy    (p_busy)
    );

    assign prod_re    = {{(W - PW){p_re[PW-1]}}, p_re};
    assign prod_im    = {{(W - PW){p_im[PW-1]}}, p_im};
    assign ring_shift = p_tag.valid | (state_reg == ST_DRAIN);
    assign ring_clear = p_tag.valid & p_tag.first;

    for (genvar i = 0; i < MAX_DIM; i++) begin : g_ring
        cmmp_acc_cell #(.W(W)) u_cell (
            .aclk    (aclk),
            .shift   (ring_shift),
            .clear   ((i == 0) ? ring_clear : 1'b0),
            .add_en  ((i == 0) ? p_tag.valid : 1'b0),
            .prev_re (acc_re[(i + MAX_DIM - 1) % MAX_DIM]),
            .prev_im (acc_im[(i + MAX_DIM - 1) % MAX_DIM]),
            .prod_re (prod_re),
            .prod_im (prod_im),
            .acc_re  (acc_re[i]),
            .acc_im  (acc_im[i])
        );
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            mode_reg    <= MODE_MUL;
            a_rows_reg  <= 4'd1;
            a_cols_reg  <= 4'd1;
            b_rows_reg  <= 4'd1;
            b_cols_reg  <= 4'd1;
            exp_reg     <= 8'd1;
            la_reg      <= '0;
            lb_reg      <= '0;
            iss_reg     <= '0;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    REG_MODE:   mode_reg   <= cfg_data[0];
                    REG_A_ROWS: a_rows_reg <= cfg_data[3:0];
                    REG_A_COLS: a_cols_reg <= cfg_data[3:0];
                    REG_B_ROWS: b_rows_reg <= cfg_data[3:0];
                    REG_B_COLS: b_cols_reg <= cfg_data[3:0];
                    REG_EXP:    exp_reg    <= cfg_data;
                    default: ;
                endcase
            end

            iss_reg.valid <= 1'b0;
            iss_reg.first <= (k_reg == '0);
            iss_mask_reg  <= (DW'(c_reg) < yc_reg);

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        if (a_we) begin
                            la_reg <= la_reg + LW'(1);
                        end
                        if (b_we) begin
                            lb_reg <= lb_reg + LW'(1);
                        end
                        r_reg <= '0;
                        k_reg <= '0;
                        c_reg <= '0;
                        er_reg <= '0;
                        ec_reg <= '0;
                        o_empty_reg <= 1'b0;
                        if (s_tlast) begin
                            la_reg <= '0;
                            lb_reg <= '0;
                            if ((mode_reg == MODE_MUL && ac != br) ||
                                (mode_reg != MODE_MUL && exp_reg > 8'd1 && ar != ac)) begin
                                o_re_reg    <= '0;
                                o_im_reg    <= '0;
                                o_row_reg   <= '0;
                                o_col_reg   <= '0;
                                o_empty_reg <= 1'b1;
                                o_last_reg  <= 1'b1;
                                state_reg   <= ST_EHOLD;
                            end else if (mode_reg == MODE_MUL) begin
                                xr_reg    <= ar;
                                n_reg     <= ac;
                                yc_reg    <= bc;
                                xwork_reg <= 1'b0;
                                ya_reg    <= 1'b0;
                                xbank_reg <= 1'b0;
                                dbank_reg <= 1'b0;
                                left_reg  <= 8'd1;
                                state_reg <= ST_CALC;
                            end else if (exp_reg > 8'd1) begin
                                xr_reg    <= ar;
                                n_reg     <= ar;
                                yc_reg    <= ar;
                                xwork_reg <= 1'b0;
                                ya_reg    <= 1'b1;
                                xbank_reg <= 1'b0;
                                dbank_reg <= 1'b0;
                                left_reg  <= exp_reg - 8'd1;
                                state_reg <= ST_CALC;
                            end else begin
                                esrc_reg  <= (exp_reg == 8'd0) ? SRC_IDENT : SRC_A;
                                erows_reg <= ar;
                                ecols_reg <= ac;
                                state_reg <= ST_ERD;
                            end
                        end
                    end
                end
                ST_CALC: begin
                    iss_reg.valid <= 1'b1;
                    if (c_reg == IDX_LAST) begin
                        c_reg <= '0;
                        if (last_k) begin
                            k_reg     <= '0;
                            state_reg <= ST_WAIT;
                        end else begin
                            k_reg <= k_reg + IW'(1);
                        end
                    end else begin
                        c_reg <= c_reg + IW'(1);
                    end
                end
                ST_WAIT: begin
                    if (!p_busy && !iss_reg.valid) begin
                        c_reg     <= '0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    if (c_reg == IDX_LAST) begin
                        c_reg <= '0;
                        if (last_r) begin
                            r_reg <= '0;
                            if (left_reg == 8'd1) begin
                                esrc_reg  <= SRC_WORK;
                                erows_reg <= xr_reg;
                                ecols_reg <= yc_reg;
                                state_reg <= ST_ERD;
                            end else begin
                                left_reg  <= left_reg - 8'd1;
                                xwork_reg <= 1'b1;
                                xbank_reg <= dbank_reg;
                                dbank_reg <= ~dbank_reg;
                                state_reg <= ST_CALC;
                            end
                        end else begin
                            r_reg     <= r_reg + IW'(1);
                            state_reg <= ST_CALC;
                        end
                    end else begin
                        c_reg <= c_reg + IW'(1);
                    end
                end
                ST_ERD: begin
                    state_reg <= ST_ELD;
                end
                ST_ELD: begin
                    case (esrc_reg)
                        SRC_IDENT: begin
                            o_re_reg <= (er_reg == ec_reg) ? ONE : '0;
                            o_im_reg <= '0;
                        end
                        SRC_A: begin
                            o_re_reg <= a_rd_a[31:0];
                            o_im_reg <= a_rd_a[63:32];
                        end
                        default: begin
                            o_re_reg <= w_rd[31:0];
                            o_im_reg <= w_rd[63:32];
                        end
                    endcase
                    o_row_reg  <= 3'(er_reg);
                    o_col_reg  <= 3'(ec_reg);
                    o_last_reg <= last_e;
                    state_reg  <= ST_EHOLD;
                end
                ST_EHOLD: begin
                    if (m_tready) begin
                        if (o_last_reg) begin
                            state_reg <= ST_IDLE;
                        end else begin
                            if ((DW'(ec_reg) + DW'(1)) == ecols_reg) begin
                                ec_reg <= '0;
                                er_reg <= er_reg + IW'(1);
                            end else begin
                                ec_reg <= ec_reg + IW'(1);
                            end
                            state_reg <= ST_ERD;
                        end
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_tvalid = (state_reg == ST_EHOLD);
    assign m_tdata  = {2'b00, o_col_reg, o_row_reg, o_im_reg, o_re_reg};
    assign m_tuser  = o_empty_reg;
    assign m_tlast  = o_last_reg;

endmodule

FILE: rtl/cmmp_ram.sv
// Generic RAM: one write port, two registered read ports.
// No dependencies.
`timescale 1ns / 1ps

module cmmp_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
    output logic [WIDTH-1:0]         rd_data_a,
    input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
    output logic [WIDTH-1:0]         rd_data_b
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_a <= mem[rd_addr_a];
        rd_data_b <= mem[rd_addr_b];
    end

endmodule

FILE: rtl/cmmp_cmul.sv
// Three-stage complex product with per-product rounding to the fixed-point grid.
// Depends on cmmp_pkg.
`timescale 1ns / 1ps

module cmmp_cmul
    import cmmp_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  cmmp_tag_t                       in_tag,
    input  logic signed [DATA_W-1:0]        x_re,
    input  logic signed [DATA_W-1:0]        x_im,
    input  logic signed [DATA_W-1:0]        y_re,
    input  logic signed [DATA_W-1:0]        y_im,
    output cmmp_tag_t                       out_tag,
    output logic signed [64-FRAC_BITS:0]    p_re,
    output logic signed [64-FRAC_BITS:0]    p_im,
    output logic                            busy
);

    localparam int RW = 64 - FRAC_BITS;
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    cmmp_tag_t tag1_reg, tag2_reg, tag3_reg;
    logic signed [63:0] rr_reg, ii_reg, ri_reg, ir_reg;
    logic signed [RW-1:0] rr2_reg, ii2_reg, ri2_reg, ir2_reg;
    logic signed [63:0] rr_h, ii_h, ri_h, ir_h;

    assign rr_h = rr_reg + HALF;
    assign ii_h = ii_reg + HALF;
    assign ri_h = ri_reg + HALF;
    assign ir_h = ir_reg + HALF;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            tag1_reg <= '0;
            tag2_reg <= '0;
            tag3_reg <= '0;
        end else begin
            tag1_reg <= in_tag;
            tag2_reg <= tag1_reg;
            tag3_reg <= tag2_reg;
        end
        rr_reg  <= x_re * y_re;
        ii_reg  <= x_im * y_im;
        ri_reg  <= x_re * y_im;
        ir_reg  <= x_im * y_re;
        // The upper bits of the biased product are its floor shift.
        rr2_reg <= rr_h[63:FRAC_BITS];
        ii2_reg <= ii_h[63:FRAC_BITS];
        ri2_reg <= ri_h[63:FRAC_BITS];
        ir2_reg <= ir_h[63:FRAC_BITS];
        p_re    <= {rr2_reg[RW-1], rr2_reg} - {ii2_reg[RW-1], ii2_reg};
        p_im    <= {ri2_reg[RW-1], ri2_reg} + {ir2_reg[RW-1], ir2_reg};
    end

    assign out_tag = tag3_reg;
    assign busy    = tag1_reg.valid | tag2_reg.valid | tag3_reg.valid;

endmodule

FILE: rtl/cmmp_acc_cell.sv
// One accumulator cell of the result-row ring; passes its value to the next cell.
// Depends on cmmp_pkg.
`timescale 1ns / 1ps

module cmmp_acc_cell
    import cmmp_pkg::*;
#(
    parameter int W = 52
) (
    input  logic                aclk,
    input  logic                shift,
    input  logic                clear,
    input  logic                add_en,
    input  logic signed [W-1:0] prev_re,
    input  logic signed [W-1:0] prev_im,
    input  logic signed [W-1:0] prod_re,
    input  logic signed [W-1:0] prod_im,
    output logic signed [W-1:0] acc_re,
    output logic signed [W-1:0] acc_im
);

    logic signed [W-1:0] base_re, base_im;

    assign base_re = clear ? '0 : prev_re;
    assign base_im = clear ? '0 : prev_im;

    always_ff @(posedge aclk) begin
        if (shift) begin
            acc_re <= base_re + (add_en ? prod_re : '0);
            acc_im <= base_im + (add_en ? prod_im : '0);
        end
    end

endmodule
